### rtl/eeb_pkg.sv
// Shared constants and control/status types for the extended Euclid block.
package eeb_pkg;

    localparam int WIDTH = 31;
    localparam int CW    = WIDTH + 1;
    localparam int KW    = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int IN_W  = 31;
    localparam int GCD_W = 31;
    localparam int COEF_W = 32;

    typedef struct packed {
        logic load;
        logic round_start;
        logic align_shift;
        logic div_step;
        logic update;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic b_zero;
        logic align_ok;
        logic k_zero;
        logic out_valid;
    } t_sts;

endpackage

### rtl/eeb_dpath.sv
// Datapath: remainder pair, shift-subtract divider and coefficient accumulators.
module eeb_dpath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  eeb_pkg::t_cmd                         i_cmd,
    output eeb_pkg::t_sts                         o_sts,
    input  logic [eeb_pkg::IN_W-1:0]              i_first_value,
    input  logic [eeb_pkg::IN_W-1:0]              i_second_value,
    input  logic                                  i_ready,
    output logic                                  o_valid,
    output logic [eeb_pkg::GCD_W-1:0]             o_divisor,
    output logic signed [eeb_pkg::COEF_W-1:0]     o_coeff_first,
    output logic signed [eeb_pkg::COEF_W-1:0]     o_coeff_second
);

    logic [eeb_pkg::WIDTH-1:0]        r_a;
    logic [eeb_pkg::WIDTH-1:0]        r_b;
    logic [eeb_pkg::WIDTH-1:0]        r_d;
    logic [eeb_pkg::KW-1:0]           r_k;
    logic signed [eeb_pkg::CW-1:0]    r_ps;
    logic signed [eeb_pkg::CW-1:0]    r_cs;
    logic signed [eeb_pkg::CW-1:0]    r_pt;
    logic signed [eeb_pkg::CW-1:0]    r_ct;
    logic signed [eeb_pkg::CW-1:0]    r_acc_s;
    logic signed [eeb_pkg::CW-1:0]    r_acc_t;
    logic                             r_out_valid;
    logic [eeb_pkg::GCD_W-1:0]        r_divisor;
    logic signed [eeb_pkg::COEF_W-1:0] r_coeff_first;
    logic signed [eeb_pkg::COEF_W-1:0] r_coeff_second;

    logic                             ge;
    logic signed [eeb_pkg::CW-1:0]    add_s;
    logic signed [eeb_pkg::CW-1:0]    add_t;

    assign ge    = (r_d <= r_a);
    assign add_s = ge ? r_cs : '0;
    assign add_t = ge ? r_ct : '0;

    assign o_sts.b_zero    = (r_b == '0);
    assign o_sts.align_ok  = ({r_d, 1'b0} <= {1'b0, r_a});
    assign o_sts.k_zero    = (r_k == '0);
    assign o_sts.out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a  <= eeb_pkg::WIDTH'(i_first_value);
            r_b  <= eeb_pkg::WIDTH'(i_second_value);
            r_ps <= eeb_pkg::CW'(1);
            r_cs <= '0;
            r_pt <= '0;
            r_ct <= eeb_pkg::CW'(1);
        end
        if (i_cmd.round_start) begin
            r_d     <= r_b;
            r_k     <= '0;
            r_acc_s <= '0;
            r_acc_t <= '0;
        end
        if (i_cmd.align_shift) begin
            r_d <= {r_d[eeb_pkg::WIDTH-2:0], 1'b0};
            r_k <= r_k + eeb_pkg::KW'(1);
        end
        if (i_cmd.div_step) begin
            if (ge) begin
                r_a <= r_a - r_d;
            end
            r_acc_s <= {r_acc_s[eeb_pkg::CW-2:0], 1'b0} + add_s;
            r_acc_t <= {r_acc_t[eeb_pkg::CW-2:0], 1'b0} + add_t;
            r_d     <= r_d >> 1;
            r_k     <= r_k - eeb_pkg::KW'(1);
        end
        if (i_cmd.update) begin
            // The old divisor becomes the dividend; the remainder becomes the divisor.
            r_a  <= r_b;
            r_b  <= r_a;
            r_ps <= r_cs;
            r_cs <= r_ps - r_acc_s;
            r_pt <= r_ct;
            r_ct <= r_pt - r_acc_t;
        end
        if (i_cmd.out_load) begin
            r_divisor      <= eeb_pkg::GCD_W'(r_a);
            r_coeff_first  <= eeb_pkg::COEF_W'(r_ps);
            r_coeff_second <= eeb_pkg::COEF_W'(r_pt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_divisor      = r_divisor;
    assign o_coeff_first  = r_coeff_first;
    assign o_coeff_second = r_coeff_second;

endmodule

### rtl/eeb_ctrl.sv
// Controller: sequences Euclid rounds of align, divide and coefficient update.
module eeb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_ready,
    input  eeb_pkg::t_sts i_sts,
    output eeb_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ALIGN,
        S_DIV,
        S_UPDATE,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.b_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.round_start = 1'b1;
                    n_state           = S_ALIGN;
                end
            end
            S_ALIGN: begin
                if (i_sts.align_ok) begin
                    o_cmd.align_shift = 1'b1;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.k_zero) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            S_FINISH: begin
                if (!i_sts.out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

### rtl/extended_euclid_bezout.sv
// Top level of the extended Euclid block: gcd and Bezout coefficients of two operands.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+----------------------------------------
//  input    | in        | i_valid / o_ready  | i_first_value, i_second_value
//  output   | out       | o_valid / i_ready  | o_divisor, o_coeff_first, o_coeff_second
//
// One transaction is worked on at a time. Each Euclid round makes k alignment
// shifts, where k is one less than the bit length of a nonzero quotient and zero
// for a zero quotient: the shared shift-subtract divider first aligns the divisor
// one bit per cycle, then retires one quotient bit per cycle. The result becomes
// valid when the rounds are done and it is loaded into the output register, and
// the input is ready again in that same cycle; a new transaction is taken only
// after the last one has been handed to the output register.
// Reset is synchronous and active low; it clears the controller state and the
// output valid flag. A result held in the output register while the consumer
// stalls does not stop the next input transaction from being accepted and
// computed; only the final hand-off into the output register waits.
module extended_euclid_bezout (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [eeb_pkg::IN_W-1:0]              i_first_value,
    input  logic [eeb_pkg::IN_W-1:0]              i_second_value,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [eeb_pkg::GCD_W-1:0]             o_divisor,
    output logic signed [eeb_pkg::COEF_W-1:0]     o_coeff_first,
    output logic signed [eeb_pkg::COEF_W-1:0]     o_coeff_second
);

    // Commands flow from the controller into the datapath; status flows back.
    eeb_pkg::t_cmd cmd;
    eeb_pkg::t_sts sts;

    // The controller steps through load, per-round alignment, division and
    // coefficient update, then hands the result to the output register.
    eeb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The datapath keeps the remainder pair, the running coefficients and
    // accumulates quotient times coefficient bit by bit as the quotient forms,
    // so no multiplier is needed.
    eeb_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_divisor      (o_divisor),
        .o_coeff_first  (o_coeff_first),
        .o_coeff_second (o_coeff_second)
    );

endmodule

### tb/tb_extended_euclid_bezout.sv
// Self-checking testbench for the extended Euclid block: gcd and Bezout coefficients.
`timescale 1ns / 1ps

module tb_extended_euclid_bezout;

    // One result transaction: gcd and the two Bezout coefficients.
    typedef struct packed {
        logic [eeb_pkg::GCD_W-1:0]         divisor;
        logic signed [eeb_pkg::COEF_W-1:0] coeff_first;
        logic signed [eeb_pkg::COEF_W-1:0] coeff_second;
    } t_bezout;

    // One row of the directed table. When has_want is set, the expected result
    // is typed into the row; otherwise the predictor works it out.
    typedef struct packed {
        logic [eeb_pkg::IN_W-1:0] x;
        logic [eeb_pkg::IN_W-1:0] y;
        logic                     has_want;
        t_bezout                  want;
    } t_stim_row;

    localparam logic [eeb_pkg::IN_W-1:0] OPERAND_MAX = '1;
    localparam int NUM_DIRECTED = 22;
    localparam int RANDOM_ITEMS = 850;
    // A quiet stretch of this length means the block has stopped handing over transactions.
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 400;

    logic                              i_clk          = 1'b0;
    logic                              i_rst_n        = 1'b0;
    logic                              i_valid        = 1'b0;
    logic                              o_ready;
    logic [eeb_pkg::IN_W-1:0]          i_first_value  = '0;
    logic [eeb_pkg::IN_W-1:0]          i_second_value = '0;
    logic                              o_valid;
    logic                              i_ready        = 1'b0;
    logic [eeb_pkg::GCD_W-1:0]         o_divisor;
    logic signed [eeb_pkg::COEF_W-1:0] o_coeff_first;
    logic signed [eeb_pkg::COEF_W-1:0] o_coeff_second;

    // Typed expectation that travels with the transaction currently offered.
    logic    row_has_want = 1'b0;
    t_bezout row_want     = '0;

    t_bezout expected_results[$];
    int      mismatches = 0;
    // While set, neither side inserts idle cycles.
    bit      calm       = 1'b0;

    extended_euclid_bezout i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_divisor      (o_divisor),
        .o_coeff_first  (o_coeff_first),
        .o_coeff_second (o_coeff_second)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Forward extended Euclid. The remainders and coefficients are kept in
    // 64-bit unsigned arithmetic; the true coefficients fit in 32 signed bits,
    // so taking the low bits at the end gives the exact two's complement value.
    function automatic t_bezout bezout_of(input logic [eeb_pkg::IN_W-1:0] x,
                                          input logic [eeb_pkg::IN_W-1:0] y);
        logic [63:0] r_prev, r_cur, r_next;
        logic [63:0] s_prev, s_cur, s_next;
        logic [63:0] t_prev, t_cur, t_next;
        logic [63:0] quot;
        t_bezout     res;
        r_prev = 64'(x);
        r_cur  = 64'(y);
        s_prev = 64'd1;
        s_cur  = 64'd0;
        t_prev = 64'd0;
        t_cur  = 64'd1;
        while (r_cur != 64'd0) begin
            quot   = r_prev / r_cur;
            r_next = r_prev - quot * r_cur;
            s_next = s_prev - quot * s_cur;
            t_next = t_prev - quot * t_cur;
            r_prev = r_cur;
            r_cur  = r_next;
            s_prev = s_cur;
            s_cur  = s_next;
            t_prev = t_cur;
            t_cur  = t_next;
        end
        res.divisor      = r_prev[eeb_pkg::GCD_W-1:0];
        res.coeff_first  = s_prev[eeb_pkg::COEF_W-1:0];
        res.coeff_second = t_prev[eeb_pkg::COEF_W-1:0];
        return res;
    endfunction

    // Directed part. The zero operands, the operand extremes and the equal
    // operands have results that follow directly from the recursion; the rest
    // (Fibonacci pairs that need the most rounds, powers of two, alternating
    // bit patterns, large primes) go through the predictor.
    t_stim_row directed_rows [0:NUM_DIRECTED-1] = '{
        '{31'd0,       31'd0,       1'b1, '{31'd0,       32'sd1, 32'sd0}},
        '{31'd1,       31'd0,       1'b1, '{31'd1,       32'sd1, 32'sd0}},
        '{31'd0,       31'd1,       1'b1, '{31'd1,       32'sd0, 32'sd1}},
        '{OPERAND_MAX, 31'd0,       1'b1, '{OPERAND_MAX, 32'sd1, 32'sd0}},
        '{31'd0,       OPERAND_MAX, 1'b1, '{OPERAND_MAX, 32'sd0, 32'sd1}},
        '{OPERAND_MAX, OPERAND_MAX, 1'b1, '{OPERAND_MAX, 32'sd0, 32'sd1}},
        '{31'd1,       31'd1,       1'b1, '{31'd1,       32'sd0, 32'sd1}},
        '{OPERAND_MAX, 31'd1,       1'b1, '{31'd1,       32'sd0, 32'sd1}},
        '{31'd1,       OPERAND_MAX, 1'b1, '{31'd1,       32'sd1, 32'sd0}},
        '{31'd1836311903, 31'd1134903170, 1'b0, '0},
        '{31'd1134903170, 31'd1836311903, 1'b0, '0},
        '{31'd1134903170, 31'd701408733,  1'b0, '0},
        '{31'h40000000,   31'h20000000,   1'b0, '0},
        '{31'h55555555,   31'h2AAAAAAA,   1'b0, '0},
        '{31'h2AAAAAAA,   31'h55555555,   1'b0, '0},
        '{OPERAND_MAX,    31'd2147483646, 1'b0, '0},
        '{31'd1000000007, 31'd998244353,  1'b0, '0},
        '{31'd240,        31'd46,         1'b0, '0},
        '{31'd12,         31'd18,         1'b0, '0},
        '{31'd3,          31'd7,          1'b0, '0},
        '{OPERAND_MAX,    31'h40000000,   1'b0, '0},
        '{31'h7FFF0000,   31'h0000FFFF,   1'b0, '0}
    };

    // Offers one input transaction and returns at the edge where it is taken.
    // Valid is only lowered when an idle gap is drawn, so it never drops and
    // rises within the same time step.
    task automatic send_operands(input logic [eeb_pkg::IN_W-1:0] x,
                                 input logic [eeb_pkg::IN_W-1:0] y,
                                 input logic                     has_want,
                                 input t_bezout                  want);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_first_value  <= x;
        i_second_value <= y;
        row_has_want   <= has_want;
        row_want       <= want;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Holds the sender back until every result in flight has been handed over.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Scoreboard. Input and output transactions are both sampled at the rising
    // edge, before any register of the block or of the testbench changes, so
    // the expectation is queued before a result of the same edge is compared.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                if (row_has_want) begin
                    expected_results = {expected_results, row_want};
                end else begin
                    expected_results = {expected_results,
                                        bezout_of(i_first_value, i_second_value)};
                end
            end
            if (o_valid && i_ready) begin : check_result
                t_bezout want;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected: divisor %0d, a %0d, b %0d",
                             $time, o_divisor, o_coeff_first, o_coeff_second);
                end else begin
                    want = expected_results.pop_front();
                    if (o_divisor !== want.divisor) begin
                        mismatches++;
                        $display("%0t: divisor expected %0d, actual %0d",
                                 $time, want.divisor, o_divisor);
                    end
                    if (o_coeff_first !== want.coeff_first) begin
                        mismatches++;
                        $display("%0t: coeff_first expected %0d, actual %0d",
                                 $time, want.coeff_first, o_coeff_first);
                    end
                    if (o_coeff_second !== want.coeff_second) begin
                        mismatches++;
                        $display("%0t: coeff_second expected %0d, actual %0d",
                                 $time, want.coeff_second, o_coeff_second);
                    end
                end
            end
        end
    end

    // Result consumer: stalls a random number of cycles before each result,
    // keeps ready high through the calm stretches.
    initial begin : result_sink
        int unsigned stall;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // Ends the run if neither channel moves a transaction for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        logic [eeb_pkg::IN_W-1:0] x_op, y_op;
        logic [eeb_pkg::IN_W-1:0] fib_lo, fib_hi, fib_sum;
        int unsigned              common, fib_n;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_operands(directed_rows[r].x, directed_rows[r].y,
                          directed_rows[r].has_want, directed_rows[r].want);
        end
        // Let the pipeline run dry once before the random part.
        wait_for_results();

        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            // Every third block of 85 transactions runs without idle cycles.
            calm = ((item / 85) % 3 == 1);
            if (item == RANDOM_ITEMS / 2) begin
                wait_for_results();
            end
            case ($urandom_range(0, 7))
                0, 1, 2: begin
                    // Full-width operands: every bit toggles over the run.
                    x_op = eeb_pkg::IN_W'($urandom());
                    y_op = eeb_pkg::IN_W'($urandom());
                end
                3: begin
                    // Operands of random bit length, so quotients vary widely.
                    x_op = eeb_pkg::IN_W'($urandom() &
                                          ((32'h1 << $urandom_range(1, 31)) - 32'h1));
                    y_op = eeb_pkg::IN_W'($urandom() &
                                          ((32'h1 << $urandom_range(1, 31)) - 32'h1));
                end
                4: begin
                    // Shared random factor, so the gcd is a multiple of it.
                    common = $urandom_range(1, 4095);
                    x_op   = eeb_pkg::IN_W'(common *
                                            $urandom_range(0, OPERAND_MAX / common));
                    y_op   = eeb_pkg::IN_W'(common *
                                            $urandom_range(0, OPERAND_MAX / common));
                end
                5: begin
                    // Consecutive Fibonacci numbers force the longest round chains.
                    fib_n  = $urandom_range(1, 45);
                    fib_lo = 31'd0;
                    fib_hi = 31'd1;
                    repeat (fib_n) begin
                        fib_sum = fib_lo + fib_hi;
                        fib_lo  = fib_hi;
                        fib_hi  = fib_sum;
                    end
                    if ($urandom_range(0, 1) == 0) begin
                        x_op = fib_hi;
                        y_op = fib_lo;
                    end else begin
                        x_op = fib_lo;
                        y_op = fib_hi;
                    end
                end
                6: begin
                    // Tiny operands hit zero, one and equal values often.
                    x_op = eeb_pkg::IN_W'($urandom_range(0, 15));
                    y_op = eeb_pkg::IN_W'($urandom_range(0, 15));
                end
                default: begin
                    // One operand random, the other at a corner or equal to it.
                    x_op = eeb_pkg::IN_W'($urandom());
                    case ($urandom_range(0, 3))
                        0:       y_op = '0;
                        1:       y_op = 31'd1;
                        2:       y_op = OPERAND_MAX;
                        default: y_op = x_op;
                    endcase
                    if ($urandom_range(0, 1) == 0) begin
                        {x_op, y_op} = {y_op, x_op};
                    end
                end
            endcase
            send_operands(x_op, y_op, 1'b0, '0);
        end

        wait_for_results();
        // Give a stray extra result time to show up.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/eeb_pkg.sv
rtl/eeb_dpath.sv
rtl/eeb_ctrl.sv
rtl/extended_euclid_bezout.sv
tb/tb_extended_euclid_bezout.sv
